### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: request and result
// payloads, function and status codes, and the per-cell command set.
// ----------------------------------------------------------------------------
package ple_pkg;

  // request function codes
  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_POS   = 3'd2;
  localparam logic [2:0] FN_DEL_FRONT = 3'd3;
  localparam logic [2:0] FN_DEL_BACK  = 3'd4;
  localparam logic [2:0] FN_DEL_POS   = 3'd5;
  localparam logic [2:0] FN_SEARCH    = 3'd6;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_BADPOS   = 3'd2;
  localparam logic [2:0] STAT_OOB      = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;
  localparam logic [2:0] STAT_FULL     = 3'd5;

  // cell commands
  localparam logic [2:0] CELL_HOLD = 3'd0;
  localparam logic [2:0] CELL_INS  = 3'd1;
  localparam logic [2:0] CELL_DEL  = 3'd2;
  localparam logic [2:0] CELL_MARK = 3'd3;
  localparam logic [2:0] CELL_SCAN = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] found_position;
    logic [6:0] list_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

### rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry and a match flag, and takes its neighbor's
// entry on insert or delete shifts and its neighbor's flag during a scan.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int IW = 6
) (
  input  logic                clk,
  input  logic [IW-1:0]       idx,
  input  logic [IW-1:0]       sel,
  input  ple_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  prev_data,
  input  logic signed [31:0]  next_data,
  input  logic                next_flag,
  output logic signed [31:0]  data,
  output logic                flag
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ple_pkg::CELL_INS: begin
        if (idx > sel) begin
          data <= prev_data;
        end else if (idx == sel) begin
          data <= ctrl.value;
        end
      end
      ple_pkg::CELL_DEL: begin
        if (idx >= sel) begin
          data <= next_data;
        end
      end
      ple_pkg::CELL_MARK: begin
        flag <= (data == ctrl.value);
      end
      ple_pkg::CELL_SCAN: begin
        flag <= next_flag;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (func, position, value) is taken at a rising edge with start
//   high and busy low. Each request gives exactly one result on rsp, shown
//   for one cycle with done high.
//   Inserts and deletes shift every cell at once: the result is registered
//   and appears in the cycle after the request, and busy stays low, so one
//   such request can be taken every cycle.
//   A search first marks every cell that matches, then walks the match flags
//   down the chain one cell per cycle, holding busy high until a match reaches
//   the head or the walk reaches the end of the list; the result appears in
//   the first cycle busy is low again.
//   Reset empties the list; entry contents are not cleared.
//   The result is not held: the receiver must take it in the cycle that
//   done is high.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ple_pkg::req_t req,
  output logic          done,
  output ple_pkg::rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state;
  logic                state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       scan_cnt;
  logic [CW-1:0]       scan_cnt_next;
  logic                done_next;
  ple_pkg::rsp_t       rsp_next;
  ple_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]       sel;

  logic signed [31:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]    cell_flag;

  logic                accept;
  logic [15:0]         pos_m1;
  logic [15:0]         count16;
  logic [CW-1:0]       count_m1;
  logic [CW-1:0]       scan_p1;
  logic [15:0]         scan_p1_16;
  logic [15:0]         count_next16;

  assign busy         = (state == ST_SCAN);
  assign accept       = start && !busy;
  assign pos_m1       = req.position - 16'd1;
  assign count16      = 16'(count);
  assign count_m1     = count - CW'(1);
  assign scan_p1      = scan_cnt + CW'(1);
  assign scan_p1_16   = 16'(scan_p1);
  assign count_next16 = 16'(count_next);

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_d;
    logic signed [31:0] next_d;
    logic               next_f;
    if (i == 0) begin : g_first
      assign prev_d = ctrl.value;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
      assign next_f = 1'b0;
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
      assign next_f = cell_flag[i+1];
    end
    ple_cell #(.IW(IW)) u_cell (
      .clk       (clk),
      .idx       (IW'(i)),
      .sel       (sel),
      .ctrl      (ctrl),
      .prev_data (prev_d),
      .next_data (next_d),
      .next_flag (next_f),
      .data      (cell_data[i]),
      .flag      (cell_flag[i])
    );
  end

  always_comb begin
    state_next              = state;
    count_next              = count;
    scan_cnt_next           = scan_cnt;
    done_next               = 1'b0;
    ctrl.op                 = ple_pkg::CELL_HOLD;
    ctrl.value              = req.value;
    sel                     = '0;
    rsp_next.status         = ple_pkg::STAT_OK;
    rsp_next.found_position = '0;
    rsp_next.list_count     = '0;
    if (state == ST_IDLE) begin
      if (accept) begin
        done_next = 1'b1;
        case (req.func)
          ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_POS: begin
            if (req.func == ple_pkg::FN_INS_POS && req.position == 16'd0) begin
              rsp_next.status = ple_pkg::STAT_BADPOS;
            end else if (count == DEPTH_C) begin
              rsp_next.status = ple_pkg::STAT_FULL;
            end else begin
              ctrl.op    = ple_pkg::CELL_INS;
              count_next = count + CW'(1);
              if (req.func == ple_pkg::FN_INS_FRONT) begin
                sel = '0;
              end else if (req.func == ple_pkg::FN_INS_BACK || pos_m1 >= count16) begin
                sel = count[IW-1:0];
              end else begin
                sel = pos_m1[IW-1:0];
              end
            end
          end
          ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK: begin
            if (count == '0) begin
              rsp_next.status = ple_pkg::STAT_EMPTY;
            end else begin
              ctrl.op    = ple_pkg::CELL_DEL;
              count_next = count_m1;
              sel        = (req.func == ple_pkg::FN_DEL_FRONT) ? '0 : count_m1[IW-1:0];
            end
          end
          ple_pkg::FN_DEL_POS: begin
            if (count == '0) begin
              rsp_next.status = ple_pkg::STAT_EMPTY;
            end else if (req.position == 16'd0) begin
              rsp_next.status = ple_pkg::STAT_BADPOS;
            end else if (req.position > count16) begin
              rsp_next.status = ple_pkg::STAT_OOB;
            end else begin
              ctrl.op    = ple_pkg::CELL_DEL;
              count_next = count_m1;
              sel        = pos_m1[IW-1:0];
            end
          end
          ple_pkg::FN_SEARCH: begin
            if (count == '0) begin
              rsp_next.status = ple_pkg::STAT_EMPTY;
            end else begin
              // mark matches, then walk the flags
              done_next     = 1'b0;
              ctrl.op       = ple_pkg::CELL_MARK;
              state_next    = ST_SCAN;
              scan_cnt_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (cell_flag[0]) begin
        done_next               = 1'b1;
        state_next              = ST_IDLE;
        rsp_next.found_position = scan_p1_16[6:0];
      end else if (scan_p1 == count) begin
        done_next       = 1'b1;
        state_next      = ST_IDLE;
        rsp_next.status = ple_pkg::STAT_NOTFOUND;
      end else begin
        ctrl.op       = ple_pkg::CELL_SCAN;
        scan_cnt_next = scan_p1;
      end
    end
    rsp_next.list_count = count_next16[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while a search is still running");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (scan_cnt < count))
    else $error("scan walked past the end of the list");

  a_front_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == ple_pkg::FN_INS_FRONT && count != DEPTH_C)
      |=> (count == $past(count) + CW'(1)))
    else $error("front insert did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ple_pkg::STAT_FULL) |-> (count == DEPTH_C))
    else $error("full status reported on a list with room");

endmodule

### tb/sv/tb_positional_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_core
// Self-checking bench for the positional list engine. A scoreboard keeps its
// own ordered list, predicts the result of every accepted request and checks
// each done strobe against it. A directed pass covers the empty-list, position
// and extreme-value corner cases; random phases then bias the mix toward inserts
// or deletes to push the list toward full or toward empty, with random gaps on the
// request side in most phases and search values mostly drawn from what it holds.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_core;

  localparam int DEPTH = 64;
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int N_RANDOM = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  ple_pkg::req_t req = '0;
  ple_pkg::rsp_t rsp;

  class list_scoreboard;
    logic signed [31:0] slots[DEPTH];
    int unsigned fill;
    ple_pkg::rsp_t exp_q[$];
    int errors;
    int checked;
    int full_hits;
    int found_hits;
    int unsigned peak;

    task flag(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void note(ple_pkg::req_t r);
      ple_pkg::rsp_t e;
      int unsigned idx;
      int unsigned p;
      e = '0;
      e.status = ple_pkg::STAT_OK;
      p = r.position;
      case (r.func)
        ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_POS: begin
          if (r.func == ple_pkg::FN_INS_POS && p == 0) begin
            e.status = ple_pkg::STAT_BADPOS;
          end else if (fill >= DEPTH) begin
            e.status = ple_pkg::STAT_FULL;
          end else begin
            if (r.func == ple_pkg::FN_INS_FRONT) idx = 0;
            else if (r.func == ple_pkg::FN_INS_BACK) idx = fill;
            else idx = (p - 1 < fill) ? p - 1 : fill;
            for (int k = fill; k > idx; k--) slots[k] = slots[k-1];
            slots[idx] = r.value;
            fill++;
          end
        end
        ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK: begin
          if (fill == 0) begin
            e.status = ple_pkg::STAT_EMPTY;
          end else begin
            idx = (r.func == ple_pkg::FN_DEL_FRONT) ? 0 : fill - 1;
            for (int k = idx; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end
        end
        ple_pkg::FN_DEL_POS: begin
          if (fill == 0) e.status = ple_pkg::STAT_EMPTY;
          else if (p == 0) e.status = ple_pkg::STAT_BADPOS;
          else if (p > fill) e.status = ple_pkg::STAT_OOB;
          else begin
            for (int k = p - 1; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end
        end
        ple_pkg::FN_SEARCH: begin
          if (fill == 0) begin
            e.status = ple_pkg::STAT_EMPTY;
          end else begin
            e.status = ple_pkg::STAT_NOTFOUND;
            for (int k = 0; k < fill; k++) begin
              if (slots[k] == r.value) begin
                e.status = ple_pkg::STAT_OK;
                e.found_position = 7'(k + 1);
                break;
              end
            end
          end
        end
        default: ;
      endcase
      e.list_count = 7'(fill);
      if (fill > peak) peak = fill;
      exp_q.push_back(e);
    endfunction

    task check(ple_pkg::rsp_t got);
      ple_pkg::rsp_t e;
      if (exp_q.size() == 0) begin
        flag($sformatf("result with no request pending: %p", got));
      end else begin
        e = exp_q.pop_front();
        checked++;
        if (e.status == ple_pkg::STAT_FULL) full_hits++;
        if (e.found_position != 0) found_hits++;
        if (got.status !== e.status)
          flag($sformatf("status got %0d exp %0d", got.status, e.status));
        if (got.found_position !== e.found_position)
          flag($sformatf("found_position got %0d exp %0d",
                         got.found_position, e.found_position));
        if (got.list_count !== e.list_count)
          flag($sformatf("list_count got %0d exp %0d", got.list_count, e.list_count));
      end
    endtask
  endclass

  list_scoreboard sb = new();
  int issued;

  positional_list_engine_core #(.DEPTH(DEPTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check(rsp);
      if (start && !busy) sb.note(req);
    end
  end

  function automatic ple_pkg::req_t mk(logic [2:0] f, logic [15:0] p,
                                       logic signed [31:0] v);
    ple_pkg::req_t r;
    r.func = f;
    r.position = p;
    r.value = v;
    return r;
  endfunction

  function automatic ple_pkg::req_t pick_req(int ins_bias);
    ple_pkg::req_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) r.func = FN_UNUSED;
    else if (roll < 22) r.func = ple_pkg::FN_SEARCH;
    else if ($urandom_range(99) < ins_bias) r.func = 3'($urandom_range(2, 0));
    else r.func = 3'($urandom_range(5, 3));
    case ($urandom_range(9))
      0: r.position = '0;
      1: r.position = 16'($urandom);
      2: r.position = 16'hFFFF;
      default: r.position = 16'($urandom_range(sb.fill + 2, 1));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: r.value = 32'($urandom_range(15)) - 32'sd8;
      4: begin
        case ($urandom_range(3))
          0: r.value = 32'sh8000_0000;
          1: r.value = 32'sh7FFF_FFFF;
          2: r.value = '0;
          default: r.value = -32'sd1;
        endcase
      end
      default: r.value = $urandom;
    endcase
    if (r.func == ple_pkg::FN_SEARCH && sb.fill > 0 && $urandom_range(99) < 60)
      r.value = sb.slots[$urandom_range(sb.fill - 1)];
    return r;
  endfunction

  task issue(ple_pkg::req_t r);
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  task hold_off(int n);
    ple_pkg::req_t junk;
    repeat (n) begin
      @(negedge clk);
      junk.func = 3'($urandom);
      junk.position = 16'($urandom);
      junk.value = $urandom;
      start <= 1'b0;
      req <= junk;
    end
  endtask

  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
  endtask

  initial begin
    int ins_bias[7];
    ins_bias = '{85, 20, 50, 92, 10, 55, 70};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(mk(ple_pkg::FN_DEL_FRONT, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_BACK, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_POS, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_POS, 16'd5, 32'sd0));
    issue(mk(ple_pkg::FN_SEARCH, 16'd0, 32'sd0));
    issue(mk(FN_UNUSED, 16'hFFFF, -32'sd1));
    issue(mk(ple_pkg::FN_INS_POS, 16'd0, 32'sd9));
    issue(mk(ple_pkg::FN_INS_POS, 16'hFFFF, 32'sd7));
    issue(mk(ple_pkg::FN_INS_FRONT, 16'd0, 32'sh8000_0000));
    issue(mk(ple_pkg::FN_INS_BACK, 16'd0, 32'sh7FFF_FFFF));
    issue(mk(ple_pkg::FN_INS_POS, 16'd2, -32'sd1));
    issue(mk(ple_pkg::FN_INS_POS, 16'd1, 32'sd0));
    issue(mk(ple_pkg::FN_INS_POS, 16'd9, 32'sd7));
    issue(mk(ple_pkg::FN_SEARCH, 16'd0, 32'sh7FFF_FFFF));
    issue(mk(ple_pkg::FN_SEARCH, 16'd0, 32'sd7));
    issue(mk(ple_pkg::FN_SEARCH, 16'd0, 32'sd12345));
    issue(mk(ple_pkg::FN_SEARCH, 16'hFFFF, 32'sh8000_0000));
    issue(mk(FN_UNUSED, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_POS, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_POS, 16'hFFFF, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_POS, 16'd2, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_FRONT, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_BACK, 16'd0, 32'sd0));
    issue(mk(ple_pkg::FN_DEL_POS, 16'd4, 32'sd0));
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300 || i == 600) drain();
      issue(pick_req(ins_bias[i / 100]));
      if (i < 300 || i >= 450)
        while ($urandom_range(99) < 34) hold_off(1);
    end
    drain();

    $display("Checked %0d results for %0d requests; list peaked at %0d of %0d entries.",
             sb.checked, issued, sb.peak, DEPTH);
    $display("Refused %0d inserts on a full list, located %0d values by search.",
             sb.full_hits, sb.found_hits);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", sb.exp_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
